@@ sv/escaped_diacritic_to_pc_decoder_assert.svh @@
// Assertion macros for the escaped-diacritic decoder checker.
// Expects clk_i and rst_ni in scope where a macro is used.
`ifndef ESCAPED_DIACRITIC_TO_PC_DECODER_ASSERT_SVH
`define ESCAPED_DIACRITIC_TO_PC_DECODER_ASSERT_SVH

// Concurrent property checked on every rising edge outside reset
`define ESCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ESCD_ASSERT_NEVER(label, cond, msg) \
  `ESCD_ASSERT(label, !(cond), msg)

`endif

@@ sv/escd_pkg.sv @@
// Shared types, constants and lookup functions for the decoder.
// No dependencies; imported by every module of the block.
package escd_pkg;

  // Special bytes of the terminal charset
  localparam logic [7:0] EscByte = 8'd25;
  localparam logic [7:0] EolByte = 8'd30;
  localparam logic [7:0] CrByte  = 8'd13;
  localparam logic [7:0] LfByte  = 8'd10;

  // Escape parser phases
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhEsc    = 2'd1;
  localparam logic [1:0] PhLetter = 2'd2;

  // Run queue between front and back (power of two)
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // One run: up to three results caused by one request
  typedef struct packed {
    logic [1:0]      num;      // results in the run, 1..3
    logic [2:0][7:0] bytes;    // data bytes, index 0 first
    logic            status;   // last result is the end-of-stream status
    logic            rev;      // flag reported with the status
  } run_t;

  // Letter code to character (A, B, C, H, K)
  function automatic logic [7:0] letter_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'd65;
      3'd1:    c = 8'd66;
      3'd2:    c = 8'd67;
      3'd3:    c = 8'd72;
      3'd4:    c = 8'd75;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Character to letter code; bit 3 set when not a letter
  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'd65:   r = 4'd0;
      8'd66:   r = 4'd1;
      8'd67:   r = 4'd2;
      8'd72:   r = 4'd3;
      8'd75:   r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  // Accented PC code for letter and base character; 0 when unknown
  function automatic logic [7:0] accent_code(input logic [2:0] idx, input logic [7:0] c);
    logic [7:0] r;
    r = 8'd0;
    case (idx)
      3'd0: begin
        case (c)
          8'd97:   r = 8'd133;
          8'd101:  r = 8'd138;
          8'd117:  r = 8'd151;
          default: r = 8'd0;
        endcase
      end
      3'd1: begin
        case (c)
          8'd101:  r = 8'd130;
          8'd69:   r = 8'd144;
          default: r = 8'd0;
        endcase
      end
      3'd2: begin
        case (c)
          8'd97:   r = 8'd131;
          8'd101:  r = 8'd136;
          8'd105:  r = 8'd140;
          8'd111:  r = 8'd147;
          8'd117:  r = 8'd150;
          default: r = 8'd0;
        endcase
      end
      3'd3: begin
        case (c)
          8'd101:  r = 8'd137;
          8'd105:  r = 8'd139;
          8'd117:  r = 8'd129;
          default: r = 8'd0;
        endcase
      end
      3'd4: begin
        case (c)
          8'd99:   r = 8'd135;
          8'd67:   r = 8'd128;
          default: r = 8'd0;
        endcase
      end
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/escd_front.sv @@
// Front end: escape parser and CR/LF tracking, one request per cycle while
// take_i is high. Builds a run of up to three results per request; uses escd_pkg.
module escd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_input_i,
  output logic               run_valid_o,
  output escd_pkg::run_t     run_o
);
  import escd_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [2:0] letter_q, letter_d;
  logic       cr_q, cr_d;
  logic       rev_q, rev_d;
  logic [3:0] lcode;
  logic [7:0] acode;
  run_t       run;

  assign lcode = letter_code(data_byte_i);
  assign acode = accent_code(letter_q, data_byte_i);

  // Classify the request and form its run
  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    cr_d     = cr_q;
    rev_d    = rev_q;
    run      = '0;
    if (end_of_input_i) begin
      // Flush pending escape bytes, report the flag, return to reset state
      run.status = 1'b1;
      if (phase_q != PhIdle) begin
        run.bytes[0] = EscByte;
        run.bytes[1] = letter_char(letter_q);
        run.num      = (phase_q == PhLetter) ? 2'd3 : 2'd2;
        run.rev      = 1'b0;
      end else begin
        run.num = 2'd1;
        run.rev = rev_q;
      end
      phase_d  = PhIdle;
      letter_d = 3'd0;
      cr_d     = 1'b0;
      rev_d    = 1'b1;
    end else begin
      cr_d = 1'b0;
      case (phase_q)
        PhIdle: begin
          if (cr_q && data_byte_i == LfByte) begin
            rev_d = 1'b0;
          end
          if (data_byte_i == EolByte) begin
            run.num      = 2'd2;
            run.bytes[0] = CrByte;
            run.bytes[1] = LfByte;
          end else if (data_byte_i == EscByte) begin
            phase_d = PhEsc;
          end else begin
            cr_d         = (data_byte_i == CrByte);
            run.num      = 2'd1;
            run.bytes[0] = data_byte_i;
          end
        end
        PhEsc: begin
          if (!lcode[3]) begin
            letter_d = lcode[2:0];
            phase_d  = PhLetter;
          end else begin
            run.num      = 2'd2;
            run.bytes[0] = EscByte;
            run.bytes[1] = data_byte_i;
            rev_d        = 1'b0;
            phase_d      = PhIdle;
          end
        end
        PhLetter: begin
          if (acode != 8'd0) begin
            run.num      = 2'd1;
            run.bytes[0] = acode;
          end else begin
            run.num      = 2'd3;
            run.bytes[0] = EscByte;
            run.bytes[1] = letter_char(letter_q);
            run.bytes[2] = data_byte_i;
            rev_d        = 1'b0;
          end
          letter_d = 3'd0;
          phase_d  = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      letter_q <= 3'd0;
      cr_q     <= 1'b0;
      rev_q    <= 1'b1;
    end else if (take_i) begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      cr_q     <= cr_d;
      rev_q    <= rev_d;
    end
  end

  assign run_valid_o = take_i && (run.num != 2'd0);
  assign run_o       = run;

endmodule

@@ sv/escd_fifo.sv @@
// Short run queue decoupling the parser from the output drain.
// Register-based, depth FifoDepth from escd_pkg.
module escd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  escd_pkg::run_t wr_data_i,
  input  logic           rd_i,
  output escd_pkg::run_t rd_data_o,
  output logic           full_o,
  output logic           avail_o
);
  import escd_pkg::*;

  localparam logic [FifoAw:0] FullCount = (FifoAw + 1)'(FifoDepth);

  run_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q, count_d;
  logic              do_wr, do_rd;

  assign full_o  = (count_q == FullCount);
  assign avail_o = (count_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && avail_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store run payload
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

@@ sv/escd_back.sv @@
// Back end: drains the head run one result per cycle into the output register
// while that register is free or being popped. Uses escd_pkg for the run type.
module escd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  escd_pkg::run_t run_i,
  output logic           rd_o,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte_o,
  output logic           byte_valid_o,
  output logic           run_last_o,
  output logic           stream_done_o,
  output logic           reversible_o
);
  import escd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  logic       load;
  logic       last;
  logic       is_status;
  logic [7:0] sel_byte;
  logic [7:0] out_byte_q;
  logic       byte_valid_q, run_last_q, done_q, rev_q;

  // Output register free or being taken this cycle
  assign load      = avail_i && (!out_valid_q || pop);
  assign last      = (idx_q + 2'd1) == run_i.num;
  assign is_status = last && run_i.status;
  assign rd_o      = load && last;

  // Select the current byte of the run
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = run_i.bytes[0];
      2'd1:    sel_byte = run_i.bytes[1];
      2'd2:    sel_byte = run_i.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  // Step through the run, restart on its last result
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= is_status ? 8'd0 : sel_byte;
      byte_valid_q <= !is_status;
      run_last_q   <= last;
      done_q       <= is_status;
      rev_q        <= is_status && run_i.rev;
    end
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;
  assign reversible_o  = rev_q;

endmodule

@@ sv/escaped_diacritic_to_pc_decoder.sv @@
// Escaped-diacritic to PC code page decoder, top level.
// Path: a request's run is written into the run queue; its results then leave via the output register.
// Throughput: one request per cycle while the four-run queue has room; results
// leave at one per cycle through the output register while each one is popped.
// Reset: asynchronous, active low; parser returns to idle with the flag set, queue empties.
module escaped_diacritic_to_pc_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       stream_done_o,
  output logic       reversible_o
);
  import escd_pkg::*;

  logic take;
  logic run_valid;
  run_t run_in, run_head;
  logic fifo_rd, fifo_avail, fifo_full;

  assign full = fifo_full;
  assign take = push && !fifo_full;

  escd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .run_valid_o    (run_valid),
    .run_o          (run_in)
  );

  escd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (run_valid),
    .wr_data_i (run_in),
    .rd_i      (fifo_rd),
    .rd_data_o (run_head),
    .full_o    (fifo_full),
    .avail_o   (fifo_avail)
  );

  escd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (fifo_avail),
    .run_i         (run_head),
    .rd_o          (fifo_rd),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .reversible_o  (reversible_o)
  );

endmodule

@@ sv/escd_checker.sv @@
// Port-level checker for the decoder, bound to the top level.
// Depends on escaped_diacritic_to_pc_decoder_assert.svh.
`include "escaped_diacritic_to_pc_decoder_assert.svh"

module escd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] data_byte_i,
  input logic       end_of_input_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       run_last_o,
  input logic       stream_done_o,
  input logic       reversible_o
);

  // A waiting result holds until taken
  `ESCD_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_byte_o) && $stable(run_last_o), "result changed while waiting")
  // The status result closes its run
  `ESCD_ASSERT(a_done_last, !empty && stream_done_o |-> run_last_o, "status result not last of run")
  // The status result carries no byte
  `ESCD_ASSERT(a_done_nobyte, !empty && stream_done_o |-> !byte_valid_o && out_byte_o == 8'd0, "status result carries a byte")
  // Only the status result lacks a byte
  `ESCD_ASSERT_NEVER(a_nobyte_status, !empty && !byte_valid_o && !stream_done_o, "empty result that is not status")
  // The flag is reported only with the status
  `ESCD_ASSERT_NEVER(a_rev_status, !empty && reversible_o && !stream_done_o, "flag outside status result")

endmodule

bind escaped_diacritic_to_pc_decoder escd_checker u_escd_checker (.*);
